[rtl/vftoi_pkg.sv]
// ----------------------------------------------------------------------------
// VAX to IEEE converter package
// Operation codes, widths and field constants shared by the converter.
// ----------------------------------------------------------------------------
package vftoi_pkg;

  localparam int unsigned WordWidth = 64;

  typedef enum logic [1:0] {
    OP_INT16  = 2'd0,
    OP_INT32  = 2'd1,
    OP_VAX_F  = 2'd2,
    OP_VAX_D  = 2'd3
  } op_t;

  // VAX exponent bias is 129; IEEE single 127, double 1023
  localparam logic [10:0] DExpOffset = 11'd894;

endpackage

[rtl/vftoi_core.sv]
// ----------------------------------------------------------------------------
// Conversion logic
// Word swap, integer pass-through, F and D float rebias and round-to-nearest-even.
// ----------------------------------------------------------------------------
module vftoi_core (
  input  logic [63:0]        raw_word,
  input  vftoi_pkg::op_t     operation,
  output logic [63:0]        converted_bits
);
  import vftoi_pkg::*;

  logic [31:0] l1;
  logic [31:0] l2;
  logic [7:0]  e;
  logic [23:0] sig;
  logic [1:0]  sh;
  logic [23:0] q_sub;
  logic [23:0] rem_mask;
  logic [23:0] rem_f;
  logic [23:0] half_f;
  logic [31:0] f_bits;
  logic [53:0] q_d;
  logic        up_d;
  logic [63:0] d_bits;

  // swap 16-bit halves of each longword
  assign l1  = {raw_word[15:0], raw_word[31:16]};
  assign l2  = {raw_word[47:32], raw_word[63:48]};
  assign e   = l1[30:23];
  assign sig = {1'b1, l1[22:0]};

  // F float: subnormal shift by 3-e for e<3
  always_comb begin
    sh       = 2'd3 - e[1:0];
    q_sub    = sig >> sh;
    rem_mask = (24'd1 << sh) - 24'd1;
    rem_f    = sig & rem_mask;
    half_f   = 24'd1 << (sh - 2'd1);
    if (rem_f > half_f || (rem_f == half_f && q_sub[0])) begin
      q_sub = q_sub + 24'd1;
    end
    if (l1 == 32'd0) begin
      f_bits = 32'd0;
    end else if (e >= 8'd3) begin
      f_bits = {l1[31], e - 8'd2, l1[22:0]};
    end else begin
      f_bits = {l1[31], 7'd0, q_sub};
    end
  end

  // D float: 56-bit significand rounded by three bits; a carry reaches 2^53
  always_comb begin
    up_d = l2[2] && (l2[1] || l2[0] || l2[3]);
    q_d  = {1'b0, sig, l2[31:3]} + {53'd0, up_d};
    if (l1 == 32'd0) begin
      d_bits = 64'd0;
    end else begin
      d_bits = {l1[31], 63'd0}
             + {1'b0, {3'd0, e} + DExpOffset, 52'd0}
             + {10'd0, q_d} - {11'd0, 1'b1, 52'd0};
    end
  end

  always_comb begin
    case (operation)
      OP_INT16: converted_bits = {48'd0, raw_word[15:0]};
      OP_INT32: converted_bits = {32'd0, raw_word[31:0]};
      OP_VAX_F: converted_bits = {32'd0, f_bits};
      default:  converted_bits = d_bits;
    endcase
  end

endmodule

[rtl/vax_float_to_ieee_converter.sv]
// ----------------------------------------------------------------------------
// VAX float to IEEE converter
// start reaches done through the input and result registers. Throughput: one word per cycle.
// busy is always low; a word enters on any cycle with start high.
// Input and result registers parted by the conversion logic.
// Synchronous active-high reset clears the valid flags only.
// ----------------------------------------------------------------------------
module vax_float_to_ieee_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] raw_word,
  input  logic [1:0]  operation,
  output logic        done,
  output logic [63:0] converted_bits
);
  import vftoi_pkg::*;

  logic        in_valid;
  logic [63:0] in_raw;
  op_t         in_op;
  logic [63:0] conv;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      in_raw <= raw_word;
      in_op  <= op_t'(operation);
    end
  end

  vftoi_core u_core (
    .raw_word       (in_raw),
    .operation      (in_op),
    .converted_bits (conv)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      converted_bits <= conv;
    end
  end

endmodule

[rtl/vftoi_checker.sv]
// ----------------------------------------------------------------------------
// Converter port checker
// Timing and format properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module vftoi_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation,
  input logic        done,
  input logic [63:0] converted_bits
);
  import vftoi_pkg::*;

  // a word started gives a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done) else $error("missing result");

  // no result without a start
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst, 2) |-> $past(start, 2)) else $error("spurious result");

  // int16 results are zero-extended
  a_int16: assert property (@(posedge clk) disable iff (rst)
    start && operation == OP_INT16 |-> ##2 converted_bits[63:16] == 48'd0)
    else $error("int16 upper bits");

  // F and int32 results occupy 32 bits
  a_f_width: assert property (@(posedge clk) disable iff (rst)
    start && (operation == OP_VAX_F || operation == OP_INT32)
    |-> ##2 converted_bits[63:32] == 32'd0) else $error("32-bit upper bits");

endmodule

bind vax_float_to_ieee_converter vftoi_checker u_checker (.*);

[tb/vax_float_to_ieee_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VAX float to IEEE converter testbench
// Drives raw file words with every operation through the start/busy
// handshake, predicts each converted word in the testbench and checks every
// done strobe against the oldest expected word. A directed table runs first,
// then random words with random sender gaps.
// ----------------------------------------------------------------------------
module vax_float_to_ieee_converter_tb;
  import vftoi_pkg::*;

  localparam int NumRandom = 1800;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 10;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] raw_word;
  logic [1:0]  operation;
  logic        done;
  logic [63:0] converted_bits;

  logic [63:0] expected_words[$];
  int          error_count;
  int          accepted_count;
  int          checked_count;
  int          idle_cycles;
  int          op_count[4];

  // Directed table: word, operation, typed expectation where obvious
  typedef struct {
    logic [63:0] word;
    op_t         op;
    bit          has_exp;
    logic [63:0] exp_bits;
  } stim_row_t;

  stim_row_t directed_rows[$];

  vax_float_to_ieee_converter DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .raw_word       (raw_word),
    .operation      (operation),
    .done           (done),
    .converted_bits (converted_bits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Swap the two 16-bit halves of a file longword
  function automatic logic [31:0] vax_long(input logic [31:0] b);
    return {b[15:0], b[31:16]};
  endfunction

  // Round right by sh bits, nearest even
  function automatic logic [63:0] shift_round_even(input logic [63:0] v, input int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q    = v >> sh;
    rem  = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Expected converted word for one raw word and operation
  function automatic logic [63:0] convert_word(input logic [63:0] w, input op_t op);
    logic [31:0] l1;
    logic [31:0] l2;
    logic [7:0]  e;
    logic [63:0] sig;
    logic [63:0] q;
    l1 = vax_long(w[31:0]);
    l2 = vax_long(w[63:32]);
    e  = l1[30:23];
    case (op)
      OP_INT16: return {48'd0, w[15:0]};
      OP_INT32: return {32'd0, w[31:0]};
      OP_VAX_F: begin
        if (l1 == 32'd0) return 64'd0;
        if (e >= 8'd3) return {32'd0, l1[31], e - 8'd2, l1[22:0]};
        sig = {40'd0, 1'b1, l1[22:0]};
        q = shift_round_even(sig, 3 - int'(e));
        return {32'd0, l1[31], 31'd0} | q;
      end
      default: begin
        if (l1 == 32'd0) return 64'd0;
        sig = {8'd0, 1'b1, l1[22:0], l2};
        q = shift_round_even(sig, 3);
        return ({l1[31], 63'd0}) + ((64'(e) + 64'd894) << 52) + (q - (64'd1 << 52));
      end
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Random word biased toward interesting exponents for the float ops
  function automatic logic [63:0] rand_float_word();
    logic [63:0] w;
    logic [31:0] l;
    w = rand_word();
    l = vax_long(w[31:0]);
    case ($urandom_range(0, 5))
      0: l[30:23] = 8'($urandom_range(0, 3));
      1: l[30:23] = 8'hFF - 8'($urandom_range(0, 1));
      2: l = 32'd0;
      3: l[2:0] = 3'b100;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) w[63:32] = {29'($urandom()), 3'b000};
    w[31:0] = vax_long(l);
    return w;
  endfunction

  // Send one word: random gap, then hold start until accepted
  task automatic send_word(input logic [63:0] w, input op_t op, input bit has_exp,
                           input logic [63:0] exp_bits);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    raw_word  <= w;
    operation <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (has_exp && exp_bits !== convert_word(w, op))
      $error("table row disagrees with predictor: word %h op %0d", w, op);
    expected_words.push_back(has_exp ? exp_bits : convert_word(w, op));
    op_count[op]++;
    accepted_count++;
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $error("converted word %h with no word outstanding", converted_bits);
          error_count++;
        end else begin
          if (converted_bits !== expected_words[0]) begin
            $error("converted_bits: expected %h, actual %h",
                   expected_words[0], converted_bits);
            error_count++;
          end
          void'(expected_words.pop_front());
          checked_count++;
        end
      end
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] w;
    op_t         op;
    error_count    = 0;
    accepted_count = 0;
    checked_count  = 0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    rst       = 1'b1;
    start     = 1'b0;
    raw_word  = '0;
    operation = OP_INT16;

    // Directed rows: extremes, zeros, dirty zero, subnormal rounding, carries
    directed_rows = '{
      '{64'd0, OP_INT16, 1'b1, 64'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, OP_INT16, 1'b1, 64'h0000_0000_0000_FFFF},
      '{64'hFFFF_FFFF_FFFF_FFFF, OP_INT32, 1'b1, 64'h0000_0000_FFFF_FFFF},
      '{64'h1234_5678_8000_0001, OP_INT32, 1'b1, 64'h0000_0000_8000_0001},
      '{64'hFFFF_FFFF_0000_0000, OP_VAX_F, 1'b1, 64'd0},
      '{64'hFFFF_FFFF_0000_0000, OP_VAX_D, 1'b1, 64'd0},
      '{64'h0000_0000_0000_4080, OP_VAX_F, 1'b1, 64'h0000_0000_3F80_0000},
      '{64'h0000_0000_0000_C080, OP_VAX_F, 1'b1, 64'h0000_0000_BF80_0000},
      '{64'h0000_0000_0000_4080, OP_VAX_D, 1'b1, 64'h3FF0_0000_0000_0000},
      '{64'h0000_0000_0001_0000, OP_VAX_F, 1'b0, 64'd0},
      '{64'h0000_0000_8000_0000, OP_VAX_F, 1'b0, 64'd0},
      '{64'h0000_0000_0001_0000, OP_VAX_D, 1'b0, 64'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, OP_VAX_F, 1'b0, 64'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, OP_VAX_D, 1'b0, 64'd0},
      '{64'hFFFF_FFFF_FFFF_7FFF, OP_VAX_D, 1'b0, 64'd0},
      '{64'h0000_0000_FFFF_017F, OP_VAX_F, 1'b0, 64'd0},
      '{64'h0000_0000_FFFF_00FF, OP_VAX_F, 1'b0, 64'd0},
      '{64'h0000_0000_0004_0000, OP_VAX_F, 1'b0, 64'd0},
      '{64'h0000_0000_000C_0000, OP_VAX_F, 1'b0, 64'd0},
      '{64'h0004_0000_0000_4080, OP_VAX_D, 1'b0, 64'd0},
      '{64'h000C_0000_0000_4080, OP_VAX_D, 1'b0, 64'd0},
      '{64'h0000_0000_0180_0000, OP_VAX_F, 1'b0, 64'd0},
      '{64'h0000_0000_0000_0180, OP_VAX_F, 1'b0, 64'd0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].op,
                directed_rows[i].has_exp, directed_rows[i].exp_bits);

    // Random words; every so often stretches with no gaps, once a full drain
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
      end
      op = op_t'($urandom_range(0, 3));
      w  = (op == OP_VAX_F || op == OP_VAX_D) ? rand_float_word() : rand_word();
      send_word(w, op, 1'b0, 64'd0);
    end
    start <= 1'b0;

    // Drain outstanding words, then idle on to catch stray strobes
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d words (int16 %0d, int32 %0d, F %0d, D %0d); checked %0d.",
             accepted_count, op_count[0], op_count[1], op_count[2], op_count[3],
             checked_count);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
